### hw/rtl/sfer_pkg.sv
`default_nettype none
package sfer_pkg;

    localparam int ROW_W   = 6;
    localparam int NROW_W  = 7;
    localparam int COL_W   = 32;
    localparam int VAL_W   = 64;
    localparam int POS_W   = 12;
    localparam int CNT_W   = 13;
    localparam int SUM_W   = 14;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 64;

    localparam logic [NROW_W-1:0] MAX_ROWS   = 7'd64;
    localparam logic [SUM_W-1:0]  MAX_OUTPUT = 14'd4096;

    // result kinds
    localparam logic [1:0] KIND_COPY    = 2'd0;
    localparam logic [1:0] KIND_DEFAULT = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    // register indexes, taken from paddr[3]
    localparam logic REG_ROW_LIMIT  = 1'b0;
    localparam logic REG_FILL_VALUE = 1'b1;

    localparam logic REQ_ENTRY = 1'b0;
    localparam logic REQ_END   = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [ROW_W-1:0] entry_row;
        logic [COL_W-1:0] entry_col;
        logic [VAL_W-1:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [1:0]       out_kind;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [VAL_W-1:0] out_value;
        logic [POS_W-1:0] out_position;
        logic             last;
    } rsp_t;

    typedef enum logic [1:0] {
        CMD_COPY,
        CMD_FILL,
        CMD_END,
        CMD_REJECT
    } cmd_kind_t;

    // one classified item: ndef defaults from first_row, then the tail
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ROW_W-1:0]  first_row;
        logic [NROW_W-1:0] ndef;
        logic [POS_W-1:0]  pos;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

### hw/rtl/sfer_front.sv
`default_nettype none
module sfer_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    input  wire sfer_pkg::req_t               req,
    input  wire logic [sfer_pkg::NROW_W-1:0]  row_limit,
    input  wire sfer_pkg::q_status_t          q_status,
    output logic                              push,
    output sfer_pkg::cmd_t                    cmd
);

    logic [sfer_pkg::NROW_W-1:0] next_row_reg, next_row_next;
    logic [sfer_pkg::CNT_W-1:0]  out_count_reg, out_count_next;

    logic [sfer_pkg::NROW_W-1:0] rows;
    logic [sfer_pkg::NROW_W-1:0] row7;
    logic [sfer_pkg::NROW_W-1:0] gap_e;
    logic [sfer_pkg::NROW_W-1:0] gap_b;
    logic [sfer_pkg::SUM_W-1:0]  sum_e;
    logic [sfer_pkg::SUM_W-1:0]  sum_b;
    logic                        bad_e;

    assign push = req_valid && !q_status.full;

    always_comb
    begin
        rows  = (row_limit > sfer_pkg::MAX_ROWS) ? sfer_pkg::MAX_ROWS : row_limit;
        row7  = {1'b0, req.entry_row};
        gap_e = (row7 >= next_row_reg) ? row7 - next_row_reg : '0;
        gap_b = (next_row_reg < rows) ? rows - next_row_reg : '0;
        sum_e = {1'b0, out_count_reg} + {{(sfer_pkg::SUM_W-sfer_pkg::NROW_W){1'b0}}, gap_e}
                + sfer_pkg::SUM_W'(1);
        sum_b = {1'b0, out_count_reg} + {{(sfer_pkg::SUM_W-sfer_pkg::NROW_W){1'b0}}, gap_b};
        bad_e = (row7 >= rows)
                || ((next_row_reg != '0) && ((row7 + 7'd1) < next_row_reg))
                || (sum_e > sfer_pkg::MAX_OUTPUT);
    end

    always_comb
    begin
        cmd.first_row  = next_row_reg[sfer_pkg::ROW_W-1:0];
        cmd.pos        = out_count_reg[sfer_pkg::POS_W-1:0];
        next_row_next  = next_row_reg;
        out_count_next = out_count_reg;
        if (req.req_type == sfer_pkg::REQ_END)
        begin
            cmd.row   = '0;
            cmd.col   = '0;
            cmd.value = '0;
            if (gap_b == '0)
            begin
                cmd.kind = sfer_pkg::CMD_END;
                cmd.ndef = '0;
            end
            else if (sum_b > sfer_pkg::MAX_OUTPUT)
            begin
                cmd.kind = sfer_pkg::CMD_REJECT;
                cmd.ndef = '0;
            end
            else
            begin
                cmd.kind = sfer_pkg::CMD_FILL;
                cmd.ndef = gap_b;
            end
            // batch closes whatever the outcome
            next_row_next  = '0;
            out_count_next = '0;
        end
        else
        begin
            cmd.row   = req.entry_row;
            cmd.col   = req.entry_col;
            cmd.value = req.entry_value;
            if (bad_e)
            begin
                cmd.kind = sfer_pkg::CMD_REJECT;
                cmd.ndef = '0;
            end
            else
            begin
                cmd.kind       = sfer_pkg::CMD_COPY;
                cmd.ndef       = gap_e;
                next_row_next  = row7 + 7'd1;
                out_count_next = sum_e[sfer_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_row_reg  <= '0;
            out_count_reg <= '0;
        end
        else if (push)
        begin
            next_row_reg  <= next_row_next;
            out_count_reg <= out_count_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/sfer_queue.sv
`default_nettype none
module sfer_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire sfer_pkg::cmd_t     wr_data,
    input  wire logic               pop,
    output sfer_pkg::cmd_t          rd_data,
    output sfer_pkg::q_status_t     status
);

    sfer_pkg::cmd_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/sfer_back.sv
`default_nettype none
module sfer_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sfer_pkg::q_status_t          q_status,
    input  wire sfer_pkg::cmd_t               q_data,
    output logic                              pop,
    input  wire logic [sfer_pkg::VAL_W-1:0]   fill_value,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output sfer_pkg::rsp_t                    rsp
);

    logic                        active_reg, active_next;
    sfer_pkg::cmd_t              cmd_reg;
    logic [sfer_pkg::NROW_W-1:0] left_reg, left_next;
    logic [sfer_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [sfer_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        out_valid_reg, out_valid_next;
    sfer_pkg::rsp_t              out_reg, out_next;

    logic load;
    logic tail;

    assign load      = !out_valid_reg || !rsp_stall;
    assign pop       = !active_reg && !q_status.empty;
    assign tail      = (cmd_reg.kind != sfer_pkg::CMD_FILL);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        active_next    = active_reg;
        left_next      = left_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            active_next = 1'b1;
            left_next   = q_data.ndef;
            row_next    = q_data.first_row;
            pos_next    = q_data.pos;
        end
        if (load)
        begin
            out_valid_next = active_reg;
            if (active_reg)
            begin
                if (left_reg != '0)
                begin
                    // inserted default for a skipped row
                    out_next.out_kind     = sfer_pkg::KIND_DEFAULT;
                    out_next.out_row      = row_reg;
                    out_next.out_col      = '0;
                    out_next.out_value    = fill_value;
                    out_next.out_position = pos_reg;
                    out_next.last         = !tail && (left_reg == 7'd1);
                    left_next             = left_reg - 7'd1;
                    row_next              = row_reg + 6'd1;
                    pos_next              = pos_reg + 12'd1;
                    if (!tail && (left_reg == 7'd1))
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    out_next.out_row      = cmd_reg.row;
                    out_next.out_col      = cmd_reg.col;
                    out_next.out_value    = cmd_reg.value;
                    out_next.out_position = '0;
                    out_next.last         = 1'b1;
                    case (cmd_reg.kind)
                        sfer_pkg::CMD_COPY:
                        begin
                            out_next.out_kind     = sfer_pkg::KIND_COPY;
                            out_next.out_position = pos_reg;
                        end
                        sfer_pkg::CMD_END:
                        begin
                            out_next.out_kind = sfer_pkg::KIND_END;
                        end
                        default:
                        begin
                            out_next.out_kind = sfer_pkg::KIND_REJECT;
                        end
                    endcase
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_data;
        end
        left_reg <= left_next;
        row_reg  <= row_next;
        pos_reg  <= pos_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/sparse_fill_empty_rows_unit.sv
// sparse_fill_empty_rows_unit: streams sparse coordinate entries in row order
// and fills every row that has no entry with a default entry.
// req channel (req_valid/req_stall/req): one sparse entry or an end-of-batch
// marker per transfer. rsp channel (rsp_valid/rsp_stall/rsp): copied entries,
// inserted defaults, batch-end or reject results, last set on the final
// result of each request.
// The front classifies a request in the cycle it is taken and posts it to a
// two-deep command queue; the back expands it one result per cycle while
// rsp_stall is low. The first result of a request passes the queue, the
// back's command registers and the output register. The back picks up the
// next command only after the last result of the current one.
// A stalled receiver holds the output register; the back then halts and the
// queue fills, after which req_stall rises.
// Registers over APB: row limit at 0x0, fill value at 0x8, 64-bit data.
// Reset clears row and position counters, queue and output valid, and
// sets the row limit to 64 and the fill value to 0.
`default_nettype none
module sparse_fill_empty_rows_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire sfer_pkg::req_t               req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output sfer_pkg::rsp_t                    rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sfer_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sfer_pkg::DATA_W-1:0]  pwdata,
    output logic [sfer_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [sfer_pkg::NROW_W-1:0] row_limit_reg;
    logic [sfer_pkg::VAL_W-1:0]  fill_value_reg;

    logic                 push;
    logic                 pop;
    sfer_pkg::cmd_t       push_cmd;
    sfer_pkg::cmd_t       head_cmd;
    sfer_pkg::q_status_t  q_status;

    assign pready    = 1'b1;
    assign req_stall = q_status.full;

    always_comb
    begin
        case (paddr[3])
            sfer_pkg::REG_ROW_LIMIT:
                prdata = {{(sfer_pkg::DATA_W-sfer_pkg::NROW_W){1'b0}}, row_limit_reg};
            default:
                prdata = fill_value_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg  <= sfer_pkg::MAX_ROWS;
            fill_value_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3])
                sfer_pkg::REG_ROW_LIMIT:
                    row_limit_reg <= pwdata[sfer_pkg::NROW_W-1:0];
                default:
                    fill_value_reg <= pwdata;
            endcase
        end
    end

    sfer_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .row_limit (row_limit_reg),
        .q_status  (q_status),
        .push      (push),
        .cmd       (push_cmd)
    );

    sfer_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .pop     (pop),
        .rd_data (head_cmd),
        .status  (q_status)
    );

    sfer_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_data     (head_cmd),
        .pop        (pop),
        .fill_value (fill_value_reg),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
`default_nettype wire
